/* design/htfc_pkg.sv */
// Shared constants and the CRC-8 byte step for the humidity/temperature frame checker.
// No dependencies; used by humidity_temp_frame_checker_unit.
package htfc_pkg;

   localparam logic [7:0]  CrcPoly     = 8'h31;
   localparam logic [7:0]  CrcInit     = 8'hFF;
   localparam logic [10:0] TempScale   = 11'd1750;
   localparam logic [11:0] TempOffset  = 12'd450;
   localparam logic [9:0]  HumScale    = 10'd1000;

   localparam logic [2:0] PosTempHi  = 3'd0;
   localparam logic [2:0] PosTempLo  = 3'd1;
   localparam logic [2:0] PosTempCrc = 3'd2;
   localparam logic [2:0] PosHumHi   = 3'd3;
   localparam logic [2:0] PosHumLo   = 3'd4;
   localparam logic [2:0] PosHumCrc  = 3'd5;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* design/humidity_temp_frame_checker_unit.sv */
// Humidity/temperature sensor frame checker: CRC-8 checks, raw pair store and scaling.
// Depends on htfc_pkg.
//
// The block takes one frame byte per transaction on the req_ channel and accepts a new byte in
// every clock cycle; a byte is registered, then checked by an unrolled CRC-8 step (polynomial
// 0x31, start 0xFF per word), so the sustained rate is one byte per cycle while results are taken.
// Six bytes make a frame: temperature high, low and CRC, then humidity high, low and CRC. The
// sixth byte, once registered, is checked and sent to the output register as one rsp_ transaction
// carrying the scaled stored pair (tenths of a degree and tenths of a percent) and both CRC
// verdicts; the stored pair is updated only when both CRCs match. A set req_tuser bit restarts
// the frame at the current byte. The result sits in an output register, so input keeps flowing
// while it waits to be taken, until the next frame's last byte has to wait in the input register.
module humidity_temp_frame_checker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [11:0] temperature_tenths, [21:12] humidity_tenths,
                                    // [22] temperature_crc_ok, [23] humidity_crc_ok
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_start_ff;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] word_ff, word_in;
   logic [15:0] pend_raw_ff, pend_raw_in;
   logic        pend_ok_ff, pend_ok_in;
   logic [15:0] stored_t_ff, stored_t_in;
   logic [15:0] stored_h_ff, stored_h_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic [2:0]  s1_pos;
   logic        s1_emit;
   logic        s1_adv;
   logic        hum_ok;
   logic [26:0] t_prod;
   logic [25:0] h_prod;
   logic [11:0] t_tenths;
   logic [9:0]  h_tenths;

   always_comb begin
      s1_pos = (s1_start_ff || (pos_ff > htfc_pkg::PosHumCrc)) ? htfc_pkg::PosTempHi : pos_ff;
      s1_emit = s1_valid_ff && (s1_pos == htfc_pkg::PosHumCrc);
      s1_adv = s1_valid_ff && (!s1_emit || !rsp_valid_ff || rsp_tready);
      req_tready = !s1_valid_ff || s1_adv;
      s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

      pos_in = pos_ff;
      crc_in = crc_ff;
      word_in = word_ff;
      pend_raw_in = pend_raw_ff;
      pend_ok_in = pend_ok_ff;
      stored_t_in = stored_t_ff;
      stored_h_in = stored_h_ff;
      hum_ok = (crc_ff == s1_byte_ff);

      if (s1_adv) begin
         case (s1_pos)
            htfc_pkg::PosTempHi, htfc_pkg::PosHumHi: begin
               crc_in = htfc_pkg::crc8_byte(htfc_pkg::CrcInit, s1_byte_ff);
               word_in = {s1_byte_ff, 8'h00};
               pos_in = s1_pos + 3'd1;
            end
            htfc_pkg::PosTempLo, htfc_pkg::PosHumLo: begin
               crc_in = htfc_pkg::crc8_byte(crc_ff, s1_byte_ff);
               word_in = {word_ff[15:8], s1_byte_ff};
               pos_in = s1_pos + 3'd1;
            end
            htfc_pkg::PosTempCrc: begin
               pend_ok_in = (crc_ff == s1_byte_ff);
               pend_raw_in = word_ff;
               crc_in = htfc_pkg::CrcInit;
               pos_in = htfc_pkg::PosHumHi;
            end
            default: begin
               crc_in = htfc_pkg::CrcInit;
               pos_in = htfc_pkg::PosTempHi;
               if (hum_ok && pend_ok_ff) begin
                  stored_t_in = pend_raw_ff;
                  stored_h_in = word_ff;
               end
            end
         endcase
      end

      t_prod = 27'(stored_t_in) * 27'(htfc_pkg::TempScale);
      h_prod = 26'(stored_h_in) * 26'(htfc_pkg::HumScale);
      t_tenths = 12'(t_prod[26:16]) - htfc_pkg::TempOffset;
      h_tenths = h_prod[25:16];
      rsp_data_in = {hum_ok, pend_ok_ff, h_tenths, t_tenths};

      if (s1_emit && s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff <= htfc_pkg::PosTempHi;
         crc_ff <= htfc_pkg::CrcInit;
         word_ff <= 16'h0000;
         pend_raw_ff <= 16'h0000;
         pend_ok_ff <= 1'b0;
         stored_t_ff <= 16'h0000;
         stored_h_ff <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         word_ff <= word_in;
         pend_raw_ff <= pend_raw_in;
         pend_ok_ff <= pend_ok_in;
         stored_t_ff <= stored_t_in;
         stored_h_ff <= stored_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_start_ff <= req_tuser;
      end
      if (s1_emit && s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= htfc_pkg::PosHumCrc)
      else $error("byte position left the frame range");

   a_emit_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_emit && rsp_valid_ff && !rsp_tready) |-> !s1_adv)
      else $error("result overwritten while the output register was still full");

   a_crc_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_pos == htfc_pkg::PosTempCrc || s1_pos == htfc_pkg::PosHumCrc))
      |=> (crc_ff == htfc_pkg::CrcInit))
      else $error("CRC not restarted after a check byte");

   a_store_good: assert property (@(posedge clock) disable iff (reset)
      (s1_emit && s1_adv && hum_ok && pend_ok_ff)
      |=> (stored_t_ff == $past(pend_raw_ff) && stored_h_ff == $past(word_ff)))
      else $error("good frame did not update the stored pair");

   a_store_hold: assert property (@(posedge clock) disable iff (reset)
      !(s1_emit && s1_adv) |=> ($stable(stored_t_ff) && $stable(stored_h_ff)))
      else $error("stored pair changed outside the end of a frame");

endmodule
